// ----- sv/gbt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gbt_pkg;
  localparam int MaxNodes = 32;
  localparam int MaxEdges = 256;
  localparam int NodeW = 5;
  localparam int EdgeW = 9;
  localparam int EaW = 8;
  localparam logic [EdgeW-1:0] EmptyMark = EdgeW'(MaxEdges);
  localparam logic [1:0] RegNodeCount = 2'd0;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_BFS   = 2'd2,
    CMD_DFS   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_NODE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BFS_POP,
    S_BFS_HEAD,
    S_BFS_EDGE,
    S_BFS_CHK,
    S_DFS_TOP,
    S_DFS_EDGE,
    S_DFS_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       do_clear;
    logic       do_add;
    logic       err;
    logic [1:0] err_code;
    logic       init_bfs;
    logic       init_dfs;
    logic       bfs_pop;
    logic       bfs_head;
    logic       bfs_edge;
    logic       bfs_chk;
    logic       dfs_top;
    logic       dfs_edge;
    logic       dfs_chk;
    logic       flush;
  } ctl_t;

  typedef struct packed {
    logic q_empty;
    logic e_empty;
    logic sp_zero;
    logic full;
  } sts_t;
endpackage
`default_nettype wire

// ----- sv/graph_bfs_dfs_traversal.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Graph traversal engine. Commands arrive on start_i when busy_o is low:
// clear, add edge, breadth-first or depth-first walk. A walk
// emits one node per result strobe, origin first, last_o on the final one;
// the receiver cannot stall, so every result shows for exactly one cycle.
// A walk reads the edge store one edge per step, for each edge leaving
// a reached node.
// Errors (range, store full) give one result with last_o set.
module graph_bfs_dfs_traversal import gbt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [4:0]  from_node_i,
  input  wire logic [4:0]  to_node_i,
  input  wire logic [4:0]  origin_node_i,
  output logic             result_valid_o,
  output logic [4:0]       visited_node_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [5:0] node_count_q;
  logic [5:0] eff;
  logic range_err;
  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == RegNodeCount) ? {26'd0, node_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 6'd32;
    end else if (psel && penable && pwrite && paddr == RegNodeCount) begin
      node_count_q <= pwdata[5:0];
    end
  end

  // effective count saturates to 1..32
  assign eff = (node_count_q == 6'd0) ? 6'd1 :
               (node_count_q > 6'd32) ? 6'd32 : node_count_q;
  assign range_err = (command_i == CMD_ADD) ?
                     ({1'b0, from_node_i} >= eff || {1'b0, to_node_i} >= eff) :
                     ({1'b0, origin_node_i} >= eff);

  gbt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .cmd_i(command_i), .range_err_i(range_err),
    .sts_i(sts), .ctl_o(ctl), .busy_o
  );

  gbt_dpath u_dpath (
    .clk_i, .rst_ni, .ctl_i(ctl), .from_i(from_node_i), .to_i(to_node_i),
    .origin_i(origin_node_i), .sts_o(sts), .res_valid_o(result_valid_o),
    .res_node_o(visited_node_o), .res_status_o(status_o), .res_last_o(last_o)
  );
endmodule
`default_nettype wire

// ----- sv/gbt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gbt_ctrl import gbt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic       range_err_i,
  input  sts_t            sts_i,
  output ctl_t            ctl_o,
  output logic            busy_o
);
  state_e state_q, state_d;
  logic go;
  assign go = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go && !range_err_i) begin
          if (cmd_i == CMD_BFS) state_d = S_BFS_POP;
          else if (cmd_i == CMD_DFS) state_d = S_DFS_TOP;
        end
      end
      S_BFS_POP:  state_d = sts_i.q_empty ? S_DONE : S_BFS_HEAD;
      S_BFS_HEAD: state_d = S_BFS_EDGE;
      S_BFS_EDGE: state_d = sts_i.e_empty ? S_BFS_POP : S_BFS_CHK;
      S_BFS_CHK:  state_d = S_BFS_EDGE;
      S_DFS_TOP:  state_d = sts_i.sp_zero ? S_DONE : S_DFS_EDGE;
      S_DFS_EDGE: state_d = S_DFS_CHK;
      S_DFS_CHK:  state_d = S_DFS_TOP;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go) begin
          if (range_err_i && cmd_i != CMD_CLEAR) begin
            ctl_o.err = 1'b1;
            ctl_o.err_code = ST_RANGE;
          end else if (cmd_i == CMD_CLEAR) begin
            ctl_o.do_clear = 1'b1;
          end else if (cmd_i == CMD_ADD) begin
            if (sts_i.full) begin
              ctl_o.err = 1'b1;
              ctl_o.err_code = ST_FULL;
            end else begin
              ctl_o.do_add = 1'b1;
            end
          end else if (cmd_i == CMD_BFS) begin
            ctl_o.init_bfs = 1'b1;
          end else begin
            ctl_o.init_dfs = 1'b1;
          end
        end
      end
      S_BFS_POP:  ctl_o.bfs_pop = 1'b1;
      S_BFS_HEAD: ctl_o.bfs_head = 1'b1;
      S_BFS_EDGE: ctl_o.bfs_edge = 1'b1;
      S_BFS_CHK:  ctl_o.bfs_chk = 1'b1;
      S_DFS_TOP:  ctl_o.dfs_top = 1'b1;
      S_DFS_EDGE: ctl_o.dfs_edge = 1'b1;
      S_DFS_CHK:  ctl_o.dfs_chk = 1'b1;
      S_DONE:     ctl_o.flush = 1'b1;
      default:    ctl_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/gbt_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gbt_dpath import gbt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  ctl_t                  ctl_i,
  input  wire logic [NodeW-1:0] from_i,
  input  wire logic [NodeW-1:0] to_i,
  input  wire logic [NodeW-1:0] origin_i,
  output sts_t                  sts_o,
  output logic                  res_valid_o,
  output logic [NodeW-1:0]      res_node_o,
  output logic [1:0]            res_status_o,
  output logic                  res_last_o
);
  // edge store: target and link, read one address a cycle
  logic [NodeW-1:0] etgt_mem [MaxEdges];
  logic [EdgeW-1:0] elnk_mem [MaxEdges];
  logic [EdgeW-1:0] head_q [MaxNodes];
  logic [EdgeW-1:0] used_q;
  logic [MaxNodes-1:0] vis_q;
  logic [NodeW-1:0] queue_mem [MaxNodes];
  logic [EdgeW-1:0] scur_mem [MaxNodes];
  logic [NodeW:0] qh_q, qt_q, sp_q;
  logic [EdgeW-1:0] e_q;
  logic [NodeW-1:0] tgt_rd_q;
  logic [EdgeW-1:0] lnk_rd_q;
  logic [NodeW-1:0] qrd_q;
  // pending output: one held node, sent on the next emit, or with last on flush
  logic             pend_q;
  logic [NodeW-1:0] pnode_q;
  logic [EdgeW-1:0] ea;

  function automatic logic [EdgeW-1:0] valid_e(logic [EdgeW-1:0] e,
                                               logic [EdgeW-1:0] used);
    return (e < used) ? e : EmptyMark;
  endfunction

  assign sts_o.full = (used_q >= EdgeW'(MaxEdges));
  assign sts_o.q_empty = !(qh_q < qt_q);
  assign sts_o.e_empty = (e_q == EmptyMark);
  assign sts_o.sp_zero = (sp_q == '0);

  logic [EdgeW-1:0] top_cur;
  logic [NodeW-1:0] spm1;
  assign spm1 = NodeW'(sp_q - 1'b1);
  assign top_cur = scur_mem[spm1];
  assign ea = ctl_i.dfs_top ? top_cur : e_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.do_add) begin
      etgt_mem[used_q[EaW-1:0]] <= to_i;
      elnk_mem[used_q[EaW-1:0]] <= head_q[from_i];
    end
    tgt_rd_q <= etgt_mem[ea[EaW-1:0]];
    lnk_rd_q <= elnk_mem[ea[EaW-1:0]];
    qrd_q <= queue_mem[qh_q[NodeW-1:0]];
    if (ctl_i.init_bfs) queue_mem[0] <= origin_i;
    if (ctl_i.bfs_chk && !vis_q[tgt_rd_q] && qt_q < (NodeW+1)'(MaxNodes))
      queue_mem[qt_q[NodeW-1:0]] <= tgt_rd_q;
    if (ctl_i.init_dfs) begin
      scur_mem[0] <= valid_e(head_q[origin_i], used_q);
    end
    // link of the top edge was read during the top step
    if (ctl_i.dfs_edge && e_q != EmptyMark)
      scur_mem[spm1] <= valid_e(lnk_rd_q, used_q);
    if (ctl_i.dfs_chk && !vis_q[tgt_rd_q] && sp_q < (NodeW+1)'(MaxNodes)) begin
      scur_mem[sp_q[NodeW-1:0]] <= valid_e(head_q[tgt_rd_q], used_q);
    end
  end

  logic emit;
  logic [NodeW-1:0] emit_node;
  always_comb begin
    emit = 1'b0;
    emit_node = '0;
    if (ctl_i.init_dfs) begin
      emit = 1'b1; emit_node = origin_i;
    end else if (ctl_i.bfs_head) begin
      emit = 1'b1; emit_node = qrd_q;
    end else if (ctl_i.dfs_chk && !vis_q[tgt_rd_q] && sp_q < (NodeW+1)'(MaxNodes)) begin
      emit = 1'b1; emit_node = tgt_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNodes; i++) head_q[i] <= EmptyMark;
      used_q <= '0;
      vis_q <= '0;
      qh_q <= '0;
      qt_q <= '0;
      sp_q <= '0;
      e_q <= EmptyMark;
      pend_q <= 1'b0;
      pnode_q <= '0;
      res_valid_o <= 1'b0;
      res_node_o <= '0;
      res_status_o <= '0;
      res_last_o <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (ctl_i.do_clear) begin
        for (int i = 0; i < MaxNodes; i++) head_q[i] <= EmptyMark;
        used_q <= '0;
      end
      if (ctl_i.do_add) begin
        head_q[from_i] <= used_q;
        used_q <= used_q + 1'b1;
      end
      if (ctl_i.err) begin
        res_valid_o <= 1'b1;
        res_node_o <= '0;
        res_status_o <= ctl_i.err_code;
        res_last_o <= 1'b1;
      end
      if (ctl_i.init_bfs) begin
        vis_q <= MaxNodes'(1) << origin_i;
        qh_q <= '0;
        qt_q <= (NodeW+1)'(1);
      end
      if (ctl_i.init_dfs) begin
        vis_q <= MaxNodes'(1) << origin_i;
        sp_q <= (NodeW+1)'(1);
      end
      if (ctl_i.bfs_pop && qh_q < qt_q) qh_q <= qh_q + 1'b1;
      if (ctl_i.bfs_head) begin
        e_q <= valid_e(head_q[qrd_q], used_q);
      end
      // link of the current edge is registered, ready in the step after its read
      if (ctl_i.bfs_chk) e_q <= valid_e(lnk_rd_q, used_q);
      if (ctl_i.bfs_chk && !vis_q[tgt_rd_q] && qt_q < (NodeW+1)'(MaxNodes)) begin
        vis_q[tgt_rd_q] <= 1'b1;
        qt_q <= qt_q + 1'b1;
      end
      if (ctl_i.dfs_top) begin
        if (top_cur == EmptyMark) sp_q <= sp_q - 1'b1;
        e_q <= top_cur;
      end
      if (ctl_i.dfs_chk) begin
        if (e_q != EmptyMark && !vis_q[tgt_rd_q] && sp_q < (NodeW+1)'(MaxNodes)) begin
          vis_q[tgt_rd_q] <= 1'b1;
          sp_q <= sp_q + 1'b1;
        end
      end
      if (emit && !(ctl_i.dfs_chk && e_q == EmptyMark)) begin
        if (pend_q) begin
          res_valid_o <= 1'b1;
          res_node_o <= pnode_q;
          res_status_o <= ST_NODE;
          res_last_o <= 1'b0;
        end
        pend_q <= 1'b1;
        pnode_q <= emit_node;
      end
      if (ctl_i.flush) begin
        res_valid_o <= 1'b1;
        res_node_o <= pnode_q;
        res_status_o <= ST_NODE;
        res_last_o <= 1'b1;
        pend_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/gbt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gbt_checker import gbt_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       result_valid_o,
  input wire logic [1:0] status_o,
  input wire logic [4:0] visited_node_o,
  input wire logic       last_o,
  input wire logic       pready
);
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_NODE |-> last_o) else $error("err no last");
  a_err_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_NODE |-> visited_node_o == 5'd0)
    else $error("err node");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o <= ST_RANGE) else $error("bad status");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule
bind graph_bfs_dfs_traversal gbt_checker u_chk (.*);
`default_nettype wire

// ----- dv/graph_walk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module graph_walk_checker import gbt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [4:0]  from_node_i,
  input  wire logic [4:0]  to_node_i,
  input  wire logic [4:0]  origin_node_i,
  input  wire logic        result_valid_i,
  input  wire logic [4:0]  visited_node_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        last_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count_o,
  output int               pending_o
);
  typedef struct packed {
    logic [4:0] node;
    status_e    status;
    logic       last;
  } visit_t;

  visit_t     visit_q[$];
  logic [5:0] node_count;
  logic [8:0] head_of[MaxNodes];
  logic [4:0] target_of[MaxEdges];
  logic [8:0] link_of[MaxEdges];
  int         edges_stored;

  assign pending_o = visit_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic logic [8:0] valid_edge(input logic [8:0] e);
    return (int'(e) < edges_stored) ? e : EmptyMark;
  endfunction

  task automatic push_visit(input logic [4:0] n, input status_e s, input logic l);
    visit_t v;
    v.node = n;
    v.status = s;
    v.last = l;
    visit_q.push_back(v);
  endtask

  task automatic predict_walk(input cmd_e c, input logic [4:0] org);
    logic       seen[MaxNodes];
    logic [4:0] fifo[MaxNodes];
    logic [4:0] stk_node[MaxNodes];
    logic [8:0] stk_cur[MaxNodes];
    int         hd, tl, sp;
    logic [8:0] e;
    logic [4:0] t;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[org] = 1'b1;
    if (c == CMD_BFS) begin
      hd = 0;
      tl = 1;
      fifo[0] = org;
      while (hd < tl) begin
        push_visit(fifo[hd], ST_NODE, 1'b0);
        e = valid_edge(head_of[fifo[hd]]);
        hd++;
        while (e != EmptyMark) begin
          t = target_of[e];
          if (!seen[t] && tl < MaxNodes) begin
            seen[t] = 1'b1;
            fifo[tl++] = t;
          end
          e = valid_edge(link_of[e]);
        end
      end
    end else begin
      push_visit(org, ST_NODE, 1'b0);
      stk_node[0] = org;
      stk_cur[0] = valid_edge(head_of[org]);
      sp = 1;
      while (sp > 0) begin
        e = stk_cur[sp-1];
        if (e == EmptyMark) begin
          sp--;
        end else begin
          stk_cur[sp-1] = valid_edge(link_of[e]);
          t = target_of[e];
          if (!seen[t] && sp < MaxNodes) begin
            seen[t] = 1'b1;
            push_visit(t, ST_NODE, 1'b0);
            stk_node[sp] = t;
            stk_cur[sp] = valid_edge(head_of[t]);
            sp++;
          end
        end
      end
    end
    visit_q[$].last = 1'b1;
  endtask

  task automatic predict_command();
    int n;
    n = (node_count < 1) ? 1 : (node_count > MaxNodes ? MaxNodes : int'(node_count));
    case (cmd_e'(command_i))
      CMD_CLEAR: begin
        foreach (head_of[i]) head_of[i] = EmptyMark;
        edges_stored = 0;
      end
      CMD_ADD: begin
        if (from_node_i >= n || to_node_i >= n) push_visit('0, ST_RANGE, 1'b1);
        else if (edges_stored >= MaxEdges) push_visit('0, ST_FULL, 1'b1);
        else begin
          target_of[edges_stored] = to_node_i;
          link_of[edges_stored] = head_of[from_node_i];
          head_of[from_node_i] = edges_stored[8:0];
          edges_stored++;
        end
      end
      default: begin
        if (origin_node_i >= n) push_visit('0, ST_RANGE, 1'b1);
        else predict_walk(cmd_e'(command_i), origin_node_i);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    visit_t v;
    if (!rst_ni) begin
      node_count = 6'd32;
      foreach (head_of[i]) head_of[i] = EmptyMark;
      edges_stored = 0;
      fail_count_o = 0;
      visit_q.delete();
    end else begin
      // results first: a result never belongs to a command taken this edge
      if (result_valid_i) begin
        if (visit_q.size() == 0) report("result with nothing expected");
        else begin
          v = visit_q.pop_front();
          if (visited_node_i != v.node)
            report($sformatf("node %0d, want %0d", visited_node_i, v.node));
          if (status_i != v.status)
            report($sformatf("status %0d, want %0d", status_i, v.status));
          if (last_i != v.last) report($sformatf("last %0b, want %0b", last_i, v.last));
        end
      end
      if (psel && penable && pwrite && paddr == RegNodeCount) node_count = pwdata[5:0];
      if (start_i && !busy_i) predict_command();
    end
  end
endmodule
`default_nettype wire

// ----- dv/tb_graph_bfs_dfs_traversal.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_graph_bfs_dfs_traversal;
  import gbt_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = CMD_CLEAR;
  logic [4:0]  from_node_i = '0;
  logic [4:0]  to_node_i = '0;
  logic [4:0]  origin_node_i = '0;
  logic        result_valid_o;
  logic [4:0]  visited_node_o;
  logic [1:0]  status_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  graph_bfs_dfs_traversal i_dut (.*);

  graph_walk_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .command_i, .from_node_i,
    .to_node_i, .origin_node_i, .result_valid_i(result_valid_o),
    .visited_node_i(visited_node_o), .status_i(status_o), .last_i(last_o),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: cycles with no accepted item and no result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_graph_bfs_dfs_traversal: errors");
      $finish;
    end
  end

  // one command, held until accepted, then a random gap
  task automatic issue(input cmd_e c, input logic [4:0] f, input logic [4:0] t,
                       input logic [4:0] o);
    int gap;
    start_i <= 1'b1;
    command_i <= c;
    from_node_i <= f;
    to_node_i <= t;
    origin_node_i <= o;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // drain all results, then let an in-flight no-result command finish
  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task automatic set_node_count(input logic [5:0] n);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegNodeCount;
    pwdata <= {26'd0, n};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [4:0] pick_node(input int lim);
    // mostly in range, sometimes any value so range errors show up
    return ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, lim - 1));
  endfunction

  // random mix of edge adds, walks and occasional clears
  task automatic random_phase(input int lim, input int items);
    int k;
    k = 0;
    while (k < items) begin
      if ($urandom_range(0, 20) == 0) issue(CMD_CLEAR, 5'($urandom), 5'($urandom), 5'($urandom));
      else if ($urandom_range(0, 2) != 0)
        issue(CMD_ADD, pick_node(lim), pick_node(lim), 5'($urandom));
      else issue($urandom_range(0, 1) ? CMD_BFS : CMD_DFS, 5'($urandom), 5'($urandom),
                 pick_node(lim));
      k++;
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty walks, self loop, ordering, range errors at the extremes
    issue(CMD_BFS, 5'd0, 5'd0, 5'd31);
    issue(CMD_DFS, 5'd31, 5'd31, 5'd0);
    issue(CMD_ADD, 5'd0, 5'd0, 5'd0);
    issue(CMD_ADD, 5'd0, 5'd1, 5'd0);
    issue(CMD_ADD, 5'd0, 5'd2, 5'd0);
    issue(CMD_ADD, 5'd1, 5'd31, 5'd0);
    issue(CMD_ADD, 5'd2, 5'd3, 5'd0);
    issue(CMD_ADD, 5'd31, 5'd0, 5'd0);
    issue(CMD_BFS, 5'd0, 5'd0, 5'd0);
    issue(CMD_DFS, 5'd0, 5'd0, 5'd0);
    issue(CMD_DFS, 5'd0, 5'd0, 5'd31);
    set_node_count(6'd4);
    issue(CMD_ADD, 5'd4, 5'd0, 5'd0);
    issue(CMD_ADD, 5'd0, 5'd31, 5'd0);
    issue(CMD_BFS, 5'd0, 5'd0, 5'd4);
    // shrunk count: old edges to node 31 still followed
    issue(CMD_BFS, 5'd0, 5'd0, 5'd1);
    issue(CMD_DFS, 5'd0, 5'd0, 5'd0);
    issue(CMD_CLEAR, 5'd31, 5'd31, 5'd31);
    issue(CMD_DFS, 5'd0, 5'd0, 5'd0);

    // store full: a long chain plus extras past capacity
    set_node_count(6'd32);
    for (int i = 0; i < MaxEdges + 3; i++)
      issue(CMD_ADD, 5'(i % 32), 5'((i * 7 + 1) % 32), 5'd0);
    issue(CMD_BFS, 5'd0, 5'd0, 5'd5);
    issue(CMD_DFS, 5'd0, 5'd0, 5'd17);
    issue(CMD_CLEAR, 5'd0, 5'd0, 5'd0);

    // zero count acts as one; count above the node range saturates
    set_node_count(6'd0);
    issue(CMD_ADD, 5'd0, 5'd0, 5'd0);
    issue(CMD_ADD, 5'd0, 5'd1, 5'd0);
    issue(CMD_BFS, 5'd0, 5'd0, 5'd0);
    set_node_count(6'd63);
    random_phase(32, 40);
    set_node_count(6'd1);
    random_phase(1, 10);
    set_node_count(6'd8);
    issue(CMD_CLEAR, 5'd0, 5'd0, 5'd0);
    random_phase(8, 40);
    set_node_count(6'd32);
    random_phase(32, 36);

    settle();
    if (fail_count == 0) $display("tb_graph_bfs_dfs_traversal: clean");
    else $display("tb_graph_bfs_dfs_traversal: errors");
    $finish;
  end
endmodule
`default_nettype wire

// ----- graph_bfs_dfs_traversal.f -----
sv/gbt_pkg.sv
sv/gbt_ctrl.sv
sv/gbt_dpath.sv
sv/graph_bfs_dfs_traversal.sv
sv/gbt_checker.sv
dv/graph_walk_checker.sv
dv/tb_graph_bfs_dfs_traversal.sv
